@@ rtl/nitfe_pkg.sv @@
// Shared constants, types and helpers for the node record table.
package nitfe_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W      = 32;

    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(TABLE_DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        word_t key;
        word_t model;
        word_t role;
    } entry_t;

    typedef struct packed {
        logic  en;
        slot_t addr;
    } store_rd_t;

    typedef struct packed {
        logic   en;
        slot_t  addr;
        entry_t entry;
    } store_wr_t;

    // ring increment with wrap at the table depth
    function automatic slot_t next_slot(input slot_t s);
        slot_t r;
        if (s == LAST_SLOT)
        begin
            r = '0;
        end
        else
        begin
            r = s + slot_t'(1);
        end
        return r;
    endfunction

endpackage

@@ rtl/nitfe_if.sv @@
// Valid/ready channel interfaces for update/lookup items and results.
interface nitfe_req_if;
    logic              valid;
    logic              ready;
    logic              op;
    nitfe_pkg::word_t  node_id;
    nitfe_pkg::word_t  model_code;
    nitfe_pkg::word_t  role_code;

    modport source (output valid, output op, output node_id, output model_code,
                    output role_code, input ready);
    modport sink   (input valid, input op, input node_id, input model_code,
                    input role_code, output ready);
endinterface

interface nitfe_rsp_if;
    logic              valid;
    logic              ready;
    logic              hit;
    logic              evicted;
    nitfe_pkg::word_t  stored_model;
    nitfe_pkg::word_t  stored_role;

    modport source (output valid, output hit, output evicted, output stored_model,
                    output stored_role, input ready);
    modport sink   (input valid, input hit, input evicted, input stored_model,
                    input stored_role, output ready);
endinterface

@@ rtl/nitfe_store.sv @@
// Record memory: key, model and role per slot, one write and one read port.
module nitfe_store (
    input  logic                 clk,
    input  nitfe_pkg::store_rd_t rd,
    input  nitfe_pkg::store_wr_t wr,
    output nitfe_pkg::entry_t    rd_data
);
    import nitfe_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/node_info_table_fifo_evict_core.sv @@
// Node record table with FIFO replacement: search sequencer and top level.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+---------------------------------------------
//  req     | in  | valid/ready  | op, node_id, model_code, role_code
//  rsp     | out | valid/ready  | hit, evicted, stored_model, stored_role
//
// The search reads one live record per cycle through the single read port of
// the store, oldest first, and stops at the first matching key. A hit ends
// the search when its record is compared; a miss first reads every live
// record, or none on an empty table.
// Reset clears the record count and ring pointer; the store holds no reset.
// req is ready only while idle, from the cycle the result is registered; a
// finished result waits in the output register, and the next item is taken
// while it waits. Its own result then holds until the register is free.
module node_info_table_fifo_evict_core (
    input logic       clk,
    input logic       rst_n,
    nitfe_req_if.sink   req,
    nitfe_rsp_if.source rsp
);
    import nitfe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t    state_reg, state_next;
    count_t    count_reg, count_next;
    slot_t     oldest_reg, oldest_next;
    slot_t     pos_reg, pos_next;
    count_t    left_reg, left_next;
    logic      rvalid_reg, rvalid_next;
    slot_t     rslot_reg, rslot_next;
    logic      op_reg, op_next;
    word_t     key_reg, key_next;
    word_t     model_reg, model_next;
    word_t     role_reg, role_next;
    logic      found_reg, found_next;
    slot_t     slot_reg, slot_next;
    word_t     fmodel_reg, fmodel_next;
    word_t     frole_reg, frole_next;
    logic      ovalid_reg, ovalid_next;
    logic      ohit_reg, ohit_next;
    logic      oevict_reg, oevict_next;
    word_t     omodel_reg, omodel_next;
    word_t     orole_reg, orole_next;

    store_rd_t rd_req;
    store_wr_t wr_req;
    entry_t    rd_data;

    word_t     keep_model, keep_role, upd_model, upd_role;
    logic      full, evict;

    nitfe_store u_store (
        .clk     (clk),
        .rd      (rd_req),
        .wr      (wr_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        keep_model = found_reg ? fmodel_reg : '0;
        keep_role  = found_reg ? frole_reg : '0;
        upd_model  = (model_reg != '0) ? model_reg : keep_model;
        upd_role   = (role_reg != '0) ? role_reg : keep_role;
        full       = (count_reg == FULL_COUNT);
        evict      = (op_reg == OP_UPDATE) && !found_reg && full;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        oldest_next = oldest_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        rvalid_next = rvalid_reg;
        rslot_next  = rslot_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        model_next  = model_reg;
        role_next   = role_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        fmodel_next = fmodel_reg;
        frole_next  = frole_reg;
        ovalid_next = ovalid_reg;
        ohit_next   = ohit_reg;
        oevict_next = oevict_reg;
        omodel_next = omodel_reg;
        orole_next  = orole_reg;

        rd_req.en    = 1'b0;
        rd_req.addr  = pos_reg;
        wr_req.en    = 1'b0;
        wr_req.addr  = slot_reg;
        wr_req.entry = '{key: key_reg, model: upd_model, role: upd_role};

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    key_next    = req.node_id;
                    model_next  = req.model_code;
                    role_next   = req.role_code;
                    pos_next    = oldest_reg;
                    left_next   = count_reg;
                    rvalid_next = 1'b0;
                    found_next  = 1'b0;
                    state_next  = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                rvalid_next = 1'b0;
                if (rvalid_reg && (rd_data.key == key_reg))
                begin
                    found_next  = 1'b1;
                    slot_next   = rslot_reg;
                    fmodel_next = rd_data.model;
                    frole_next  = rd_data.role;
                    state_next  = ST_DONE;
                end
                else if ((left_reg == '0) && !rvalid_reg)
                begin
                    // miss: the scan pointer now sits on the tail slot, which
                    // is also the oldest slot when the table is full
                    found_next = 1'b0;
                    slot_next  = pos_reg;
                    state_next = ST_DONE;
                end
                else if (left_reg != '0)
                begin
                    rd_req.en   = 1'b1;
                    rvalid_next = 1'b1;
                    rslot_next  = pos_reg;
                    pos_next    = next_slot(pos_reg);
                    left_next   = left_reg - count_t'(1);
                end
            end

            ST_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ohit_next   = found_reg;
                    oevict_next = evict;
                    if (op_reg == OP_LOOKUP)
                    begin
                        omodel_next = keep_model;
                        orole_next  = keep_role;
                    end
                    else
                    begin
                        omodel_next = upd_model;
                        orole_next  = upd_role;
                        wr_req.en   = 1'b1;
                        if (!found_reg)
                        begin
                            if (full)
                            begin
                                oldest_next = next_slot(oldest_reg);
                            end
                            else
                            begin
                                count_next = count_reg + count_t'(1);
                            end
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            oldest_reg <= '0;
            pos_reg    <= '0;
            left_reg   <= '0;
            rvalid_reg <= 1'b0;
            rslot_reg  <= '0;
            op_reg     <= OP_UPDATE;
            key_reg    <= '0;
            model_reg  <= '0;
            role_reg   <= '0;
            found_reg  <= 1'b0;
            slot_reg   <= '0;
            fmodel_reg <= '0;
            frole_reg  <= '0;
            ovalid_reg <= 1'b0;
            ohit_reg   <= 1'b0;
            oevict_reg <= 1'b0;
            omodel_reg <= '0;
            orole_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
            pos_reg    <= pos_next;
            left_reg   <= left_next;
            rvalid_reg <= rvalid_next;
            rslot_reg  <= rslot_next;
            op_reg     <= op_next;
            key_reg    <= key_next;
            model_reg  <= model_next;
            role_reg   <= role_next;
            found_reg  <= found_next;
            slot_reg   <= slot_next;
            fmodel_reg <= fmodel_next;
            frole_reg  <= frole_next;
            ovalid_reg <= ovalid_next;
            ohit_reg   <= ohit_next;
            oevict_reg <= oevict_next;
            omodel_reg <= omodel_next;
            orole_reg  <= orole_next;
        end
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = ovalid_reg;
    assign rsp.hit          = ohit_reg;
    assign rsp.evicted      = oevict_reg;
    assign rsp.stored_model = omodel_reg;
    assign rsp.stored_role  = orole_reg;

endmodule
